// ----- src/hfc_pkg.sv -----
// Shared constants, request and status codes, and helpers for header_field_capture.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package hfc_pkg;
    localparam int SLOTS     = 16;
    localparam int NAME_MAX  = 80;
    localparam int VALUE_MAX = 4095;

    localparam int SLOT_W = 4;
    localparam int CNT_W  = 5;
    localparam int POS_W  = 7;
    localparam int CAP_W  = 12;
    localparam int ROW_W  = SLOTS * 8 + 8;

    localparam logic [2:0] REQ_LOAD_CHAR = 3'd0;
    localparam logic [2:0] REQ_LOAD_LEN  = 3'd1;
    localparam logic [2:0] REQ_NAME_BYTE = 3'd2;
    localparam logic [2:0] REQ_VALUE     = 3'd3;
    localparam logic [2:0] REQ_HDR_END   = 3'd4;
    localparam logic [2:0] REQ_NEW_MSG   = 3'd5;

    localparam logic [2:0] ST_ACCEPTED  = 3'd0;
    localparam logic [2:0] ST_STORED    = 3'd1;
    localparam logic [2:0] ST_NO_SLOT   = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_NAME_DROP = 3'd4;

    // Lower-case an ASCII letter, pass anything else.
    function automatic logic [7:0] fold_case(input logic [7:0] c);
        fold_case = (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
    endfunction
endpackage
`default_nettype wire

// ----- src/hfc_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module hfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_waddr,
    input  wire [WIDTH-1:0]         i_wdata,
    input  wire [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]        o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write, and register the read data (a read of the address being written returns the old word)
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ----- src/header_field_capture.sv -----
// Header field capture top level: request decode, name match, slot bookkeeping.
// Depends on hfc_pkg and hfc_ram (name table row memory).
// Each request is held in the request registers while its row is read, then executed, and
// its result is registered to the output; a new request is not taken until the held one
// is executed, and execution waits while an unaccepted result is on the output.
// Reset: synchronous active-low; clears slot count, name length, match counters, slot use
// and fill, current slot, busy and output valid; the name table itself is kept uninitialized.
`timescale 1ns / 1ps
`default_nettype none
module header_field_capture (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire [4:0]   i_cfg_slot_count,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire [2:0]   i_req_type,
    input  wire [3:0]   i_slot,
    input  wire [6:0]   i_char_pos,
    input  wire [7:0]   i_data_byte,
    input  wire [11:0]  i_capacity,
    output logic        o_valid,
    input  wire         i_ready,
    output logic [2:0]  o_status,
    output logic [3:0]  o_slot_index,
    output logic [11:0] o_value_offset,
    output logic [7:0]  o_value_byte
);
    localparam int S  = hfc_pkg::SLOTS;
    localparam int PW = hfc_pkg::POS_W;
    localparam int CW = hfc_pkg::CAP_W;
    localparam int NW = hfc_pkg::CNT_W;
    localparam int AW = $clog2(hfc_pkg::NAME_MAX);

    logic [NW-1:0] r_slot_count;
    logic [PW-1:0] r_len, n_len;
    logic [NW-1:0] r_cur, n_cur;
    logic [S-1:0]  r_taken, n_taken;
    logic [CW-1:0] r_fill [S];
    logic [CW-1:0] n_fill [S];
    logic [PW-1:0] r_mis [S];
    logic [PW-1:0] n_mis [S];
    logic [PW-1:0] r_wlen [S];
    logic [PW-1:0] n_wlen [S];
    logic [CW-1:0] r_cap [S];
    logic [CW-1:0] n_cap [S];

    logic          r_busy;
    logic [2:0]    r_type;
    logic [3:0]    r_slot;
    logic [6:0]    r_pos;
    logic [7:0]    r_byte;
    logic [11:0]   r_capin;
    logic [AW-1:0] r_addr;

    logic          r_ov;
    logic [2:0]    r_status, n_status;
    logic [3:0]    r_oslot, n_oslot;
    logic [11:0]   r_ooff, n_ooff;
    logic [7:0]    r_obyte, n_obyte;

    logic                      in_acc, done, we;
    logic [AW-1:0]             in_addr, raddr;
    logic [hfc_pkg::ROW_W-1:0] rd, wd;
    logic [NW-1:0]             live;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = !r_busy;
    assign in_acc      = i_valid && !r_busy;
    assign done        = r_busy && (!r_ov || i_ready);
    assign live = (r_slot_count > NW'(S)) ? NW'(S) : r_slot_count;

    // Pick the row for the new request: table position or next typed position
    always_comb begin
        in_addr = '0;
        if (i_req_type == hfc_pkg::REQ_LOAD_CHAR && 32'(i_char_pos) < hfc_pkg::NAME_MAX
                && 32'(i_slot) < S) begin
            in_addr = i_char_pos[AW-1:0];
        end else if (i_req_type == hfc_pkg::REQ_NAME_BYTE
                && 32'(r_len) < hfc_pkg::NAME_MAX) begin
            in_addr = r_len[AW-1:0];
        end
    end
    assign raddr = in_acc ? in_addr : r_addr;

    hfc_ram #(.WIDTH(hfc_pkg::ROW_W), .DEPTH(hfc_pkg::NAME_MAX)) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_addr),
        .i_wdata (wd),
        .i_raddr (raddr),
        .o_rdata (rd)
    );

    // Execute the held request against the row read back
    always_comb begin
        logic [7:0]  tch, old_c;
        logic        old_m, new_m, found;
        logic [NW-1:0] pick;
        logic [CW-1:0] capv;
        int          sl;
        n_len = r_len; n_cur = r_cur; n_taken = r_taken;
        n_fill = r_fill; n_mis = r_mis; n_wlen = r_wlen; n_cap = r_cap;
        n_status = hfc_pkg::ST_ACCEPTED;
        n_oslot = '0; n_ooff = '0; n_obyte = '0;
        we = 1'b0; wd = rd;
        tch = rd[S*8 +: 8];
        old_c = '0; old_m = 1'b0; new_m = 1'b0; found = 1'b0; pick = NW'(S);
        capv = '0;
        sl = 32'(r_slot);
        unique case (r_type)
            hfc_pkg::REQ_LOAD_CHAR: begin
                if (32'(r_pos) < hfc_pkg::NAME_MAX && sl < S) begin
                    we = 1'b1;
                    old_c = rd[sl*8 +: 8];
                    wd[sl*8 +: 8] = r_byte;
                    // Correct the lane's mismatch count inside the typed name
                    if (r_pos < r_len) begin
                        old_m = hfc_pkg::fold_case(old_c) != hfc_pkg::fold_case(tch);
                        new_m = hfc_pkg::fold_case(r_byte) != hfc_pkg::fold_case(tch);
                        if (old_m && !new_m) n_mis[sl] = r_mis[sl] - 1'b1;
                        else if (!old_m && new_m) n_mis[sl] = r_mis[sl] + 1'b1;
                    end
                end
            end
            hfc_pkg::REQ_LOAD_LEN: begin
                if (sl < S) begin
                    n_wlen[sl] = (32'(r_pos) > hfc_pkg::NAME_MAX)
                        ? PW'(hfc_pkg::NAME_MAX) : r_pos;
                    n_cap[sl] = (32'(r_capin) > hfc_pkg::VALUE_MAX)
                        ? CW'(hfc_pkg::VALUE_MAX) : r_capin;
                end
            end
            hfc_pkg::REQ_NAME_BYTE: begin
                if (32'(r_len) < hfc_pkg::NAME_MAX) begin
                    we = 1'b1;
                    wd[S*8 +: 8] = r_byte;
                    n_len = r_len + 1'b1;
                    for (int e = 0; e < S; e++) begin
                        if (hfc_pkg::fold_case(rd[e*8 +: 8]) != hfc_pkg::fold_case(r_byte))
                            n_mis[e] = r_mis[e] + 1'b1;
                    end
                end else begin
                    n_status = hfc_pkg::ST_NAME_DROP;
                end
            end
            hfc_pkg::REQ_VALUE: begin
                if (r_len != '0) begin
                    // Take the first free entry whose name matches
                    for (int e = S - 1; e >= 0; e--) begin
                        if (NW'(e) < live && !r_taken[e] && r_wlen[e] == r_len
                                && r_mis[e] == '0) begin
                            found = 1'b1;
                            pick = NW'(e);
                        end
                    end
                    n_cur = pick;
                    if (found) begin
                        n_taken[pick[NW-2:0]] = 1'b1;
                        n_fill[pick[NW-2:0]]  = '0;
                    end
                    n_len = '0;
                    for (int e = 0; e < S; e++) n_mis[e] = '0;
                end
                if (n_cur < live) begin
                    capv = n_cap[n_cur[NW-2:0]];
                    if (n_fill[n_cur[NW-2:0]] < capv) begin
                        n_status = hfc_pkg::ST_STORED;
                        n_oslot  = n_cur[3:0];
                        n_ooff   = n_fill[n_cur[NW-2:0]];
                        n_obyte  = r_byte;
                        n_fill[n_cur[NW-2:0]] = n_fill[n_cur[NW-2:0]] + 1'b1;
                    end else begin
                        n_status = hfc_pkg::ST_FULL;
                    end
                end else begin
                    n_status = hfc_pkg::ST_NO_SLOT;
                end
            end
            hfc_pkg::REQ_HDR_END: begin
                n_len = '0;
                for (int e = 0; e < S; e++) n_mis[e] = '0;
            end
            hfc_pkg::REQ_NEW_MSG: begin
                n_len = '0;
                n_cur = NW'(S);
                n_taken = '0;
                for (int e = 0; e < S; e++) begin
                    n_mis[e] = '0;
                    n_fill[e] = '0;
                end
            end
            default: begin
            end
        endcase
        if (!done) we = 1'b0;
    end

    // Hold the request, advance state, and present the result
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_type  <= i_req_type;
            r_slot  <= i_slot;
            r_pos   <= i_char_pos;
            r_byte  <= i_data_byte;
            r_capin <= i_capacity;
            r_addr  <= in_addr;
        end
        if (done) begin
            r_wlen   <= n_wlen;
            r_cap    <= n_cap;
            r_status <= n_status;
            r_oslot  <= n_oslot;
            r_ooff   <= n_ooff;
            r_obyte  <= n_obyte;
        end
        if (!i_rst_n) begin
            r_slot_count <= '0;
            r_len   <= '0;
            r_cur   <= NW'(S);
            r_taken <= '0;
            r_busy  <= 1'b0;
            r_ov    <= 1'b0;
            for (int e = 0; e < S; e++) begin
                r_fill[e] <= '0;
                r_mis[e]  <= '0;
            end
        end else begin
            if (i_cfg_valid) r_slot_count <= i_cfg_slot_count;
            if (in_acc) r_busy <= 1'b1;
            else if (done) r_busy <= 1'b0;
            if (done) begin
                r_ov    <= 1'b1;
                r_len   <= n_len;
                r_cur   <= n_cur;
                r_taken <= n_taken;
                r_fill  <= n_fill;
                r_mis   <= n_mis;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_valid        = r_ov;
    assign o_status       = r_status;
    assign o_slot_index   = r_oslot;
    assign o_value_offset = r_ooff;
    assign o_value_byte   = r_obyte;
endmodule
`default_nettype wire
